/* sv/accel_double_tap_detector_defines.svh */
// Assertion macros shared by the double tap detector RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ACCEL_DOUBLE_TAP_DETECTOR_DEFINES_SVH
`define ACCEL_DOUBLE_TAP_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, ignored while reset is low.
`define ADT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that must hold at every edge, reset included.
`define ADT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/adt_pkg.sv */
package adt_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int KERNEL_PAIRS = 8;
  localparam int SAMPLE_BITS  = 16;

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int KCNT_W = $clog2(KERNEL_PAIRS + 1);
  localparam int SUM_W  = SAMPLE_BITS + KCNT_W;

  // Configuration register indexes; the byte address is the index times 4
  typedef enum logic [1:0] {
    REG_MIN_DELTA    = 2'd0,
    REG_SETTLE_DELTA = 2'd1,
    REG_TAPS_NEEDED  = 2'd2,
    REG_FILL_VALUE   = 2'd3
  } reg_idx_e;

  // Sum accumulator control, sequencer to shared unit
  typedef struct packed {
    logic load;   // start a new sum from the fresh sample
    logic accum;  // add |prev - sample| and hold the sample as prev
  } acc_ctrl_t;

endpackage

/* sv/adt_ram.sv */
module adt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/adt_sad_unit.sv */
module adt_sad_unit import adt_pkg::*; (
  input  logic                   clk_i,
  input  acc_ctrl_t              ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SUM_W-1:0]       sum_o
);

  logic [SAMPLE_BITS-1:0] prev_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] diff;

  // Absolute difference of the neighboring pair
  assign diff = (sample_i >= prev_q) ? (sample_i - prev_q) : (prev_q - sample_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prev_q <= sample_i;
      sum_q  <= '0;
    end else if (ctrl_i.accum) begin
      prev_q <= sample_i;
      sum_q  <= sum_q + SUM_W'(diff);
    end
  end

  assign sum_o = sum_q;

endmodule

/* sv/accel_double_tap_detector.sv */
// Double tap detector for accelerometer magnitude samples.
// Input stream (s_axis): one 16-bit magnitude per transaction in tdata.
// Output stream (m_axis): one result per input transaction, tdata bit 0 is
// double_tap, bit 1 tap_start, bit 2 settling, bits 7:3 zero.
// Configuration: APB registers min_delta (0x0), settle_delta (0x4),
// taps_needed (0x8) and fill_value (0xC); write them only while idle.
// Each sample goes into a 32-entry window RAM; one shared abs-diff
// accumulator then walks the 8 neighboring pairs behind it, one RAM read
// and one accumulate per pair (separate states, as the RAM read port is
// registered), followed by the decision state.
// The output register is loaded as the decision state completes. s_axis
// tready is high only while the sequencer is idle, so a new sample is not
// taken until the last one is decided.
// A stalled m_axis holds its result; the decision cycle waits until the
// output register is free, so no result is lost.
// Reset: registers return to their defaults, the window reads as the fill
// value, all tap marks clear, the detector is armed. No clearing pass is
// needed: window refills just clear the per-entry valid bits.
module accel_double_tap_detector import adt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] magnitude
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] double_tap, [1] tap_start, [2] settling
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "accel_double_tap_detector_defines.svh"

  localparam int DELTA_W  = 16;
  localparam int TARGET_W = 6;
  localparam int CNT_W    = 6;
  localparam int THR_W    = DELTA_W + KCNT_W;
  localparam int CMP_W    = (SUM_W > THR_W) ? SUM_W : THR_W;

  localparam logic [DELTA_W-1:0]  MIN_DELTA_RST    = 16'd500;
  localparam logic [DELTA_W-1:0]  SETTLE_DELTA_RST = 16'd800;
  localparam logic [TARGET_W-1:0] TAPS_NEEDED_RST  = 6'd2;
  localparam logic [DELTA_W-1:0]  FILL_VALUE_RST   = 16'd8234;
  localparam logic [CNT_W-1:0]    COUNT_MAX        = '1;
  localparam logic [PTR_W-1:0]    PTR_LAST         = PTR_W'(WINDOW_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_DECIDE
  } state_e;

  // Configuration registers
  logic [DELTA_W-1:0]  min_delta_q, settle_delta_q, fill_value_q;
  logic [TARGET_W-1:0] taps_needed_q;
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  // Sequencer and detector state
  state_e                 state_q;
  logic [PTR_W-1:0]       wp_q, rd_ptr_q;
  logic [KCNT_W-1:0]      k_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   settle_q;
  logic [WINDOW_DEPTH-1:0] vld_q;   // window entry written since last refill
  logic [WINDOW_DEPTH-1:0] mark_q;  // tap marks
  logic [SAMPLE_BITS-1:0] fill_q;   // value an unwritten entry reads as
  logic                   vld_rd_q;

  // Output register
  logic out_vld_q, out_dbl_q, out_tap_q, out_set_q;

  // Datapath
  logic [SAMPLE_BITS-1:0] sample_in, ram_rdata, unit_din;
  logic [SUM_W-1:0]       sum;
  acc_ctrl_t              acc_ctrl;
  logic                   in_fire, advance;

  // Decision
  logic [CMP_W-1:0] sum_x, thr_min, thr_set;
  logic [PTR_W-1:0] wp_nx, rd_nx;
  logic [CNT_W-1:0] cnt_inc, cnt_dec;
  logic             tap, settle_end, dbl, refill, settle_nx;

  //--------------------------------------------------------------------------
  // APB: always ready, zero wait states
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_MIN_DELTA:    prdata = 32'(min_delta_q);
      REG_SETTLE_DELTA: prdata = 32'(settle_delta_q);
      REG_TAPS_NEEDED:  prdata = 32'(taps_needed_q);
      REG_FILL_VALUE:   prdata = 32'(fill_value_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_delta_q    <= MIN_DELTA_RST;
      settle_delta_q <= SETTLE_DELTA_RST;
      taps_needed_q  <= TAPS_NEEDED_RST;
      fill_value_q   <= FILL_VALUE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_DELTA:    min_delta_q    <= pwdata[DELTA_W-1:0];
        REG_SETTLE_DELTA: settle_delta_q <= pwdata[DELTA_W-1:0];
        REG_TAPS_NEEDED:  taps_needed_q  <= pwdata[TARGET_W-1:0];
        REG_FILL_VALUE:   fill_value_q   <= pwdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Handshakes
  //--------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // Decision may proceed once the output register is free or being drained
  assign advance       = (state_q == S_DECIDE) && (!out_vld_q || m_axis_tready);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_set_q, out_tap_q, out_dbl_q};

  //--------------------------------------------------------------------------
  // Window RAM and shared abs-diff accumulator
  //--------------------------------------------------------------------------
  assign sample_in = SAMPLE_BITS'(s_axis_tdata);

  adt_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (wp_q),
    .wdata_i (sample_in),
    .re_i    (state_q == S_READ),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // An entry not written since the last refill reads as the fill value
  assign unit_din = (state_q == S_IDLE) ? sample_in :
                    (vld_rd_q ? ram_rdata : fill_q);

  assign acc_ctrl.load  = in_fire;
  assign acc_ctrl.accum = (state_q == S_ACC);

  adt_sad_unit u_sad (
    .clk_i    (clk_i),
    .ctrl_i   (acc_ctrl),
    .sample_i (unit_din),
    .sum_o    (sum)
  );

  //--------------------------------------------------------------------------
  // Mode decision, count update, double tap test
  //--------------------------------------------------------------------------
  assign wp_nx = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign rd_nx = (rd_ptr_q == '0) ? PTR_LAST : rd_ptr_q - 1'b1;

  always_comb begin
    sum_x      = CMP_W'(sum);
    thr_min    = CMP_W'(THR_W'(min_delta_q) * THR_W'(KERNEL_PAIRS));
    thr_set    = CMP_W'(THR_W'(settle_delta_q) * THR_W'(KERNEL_PAIRS));
    tap        = !settle_q && (sum_x > thr_min);
    settle_end = settle_q && (sum_x < thr_set);
    settle_nx  = tap ? 1'b1 : (settle_end ? 1'b0 : settle_q);
    // Saturate on a new tap, then drop the mark aging out at the next slot
    cnt_inc    = (tap && (cnt_q != COUNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
    cnt_dec    = ((cnt_inc != '0) && mark_q[wp_nx]) ? cnt_inc - 1'b1 : cnt_inc;
    dbl        = (cnt_dec >= taps_needed_q);
    refill     = settle_end || dbl;
  end

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      rd_ptr_q  <= '0;
      k_q       <= '0;
      cnt_q     <= '0;
      settle_q  <= 1'b0;
      vld_q     <= '0;
      mark_q    <= '0;
      fill_q    <= SAMPLE_BITS'(FILL_VALUE_RST);
      vld_rd_q  <= 1'b0;
      out_vld_q <= 1'b0;
      out_dbl_q <= 1'b0;
      out_tap_q <= 1'b0;
      out_set_q <= 1'b0;
    end else begin
      // Drop a taken result unless the decision reloads the register now
      if (m_axis_tvalid && m_axis_tready && !advance) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            vld_q[wp_q] <= 1'b1;
            rd_ptr_q    <= (wp_q == '0) ? PTR_LAST : wp_q - 1'b1;
            k_q         <= KCNT_W'(1);
            state_q     <= S_READ;
          end
        end
        S_READ: begin
          vld_rd_q <= vld_q[rd_ptr_q];
          state_q  <= S_ACC;
        end
        S_ACC: begin
          rd_ptr_q <= rd_nx;
          if (k_q == KCNT_W'(KERNEL_PAIRS)) begin
            state_q <= S_DECIDE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_DECIDE: begin
          if (advance) begin
            mark_q[wp_q] <= tap;
            wp_q         <= wp_nx;
            settle_q     <= settle_nx;
            cnt_q        <= dbl ? '0 : cnt_dec;
            if (refill) begin
              vld_q  <= '0;
              fill_q <= SAMPLE_BITS'(fill_value_q);
            end
            out_vld_q <= 1'b1;
            out_dbl_q <= dbl;
            out_tap_q <= tap;
            out_set_q <= settle_nx;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  `ADT_ASSERT(a_fire_starts_walk, clk_i, rst_ni, in_fire |=> (state_q == S_READ) && (k_q == KCNT_W'(1)), "accepted sample did not start the pair walk")
  `ADT_ASSERT(a_pair_count_range, clk_i, rst_ni, (state_q == S_ACC) |-> (k_q != '0) && (k_q <= KCNT_W'(KERNEL_PAIRS)), "pair counter out of range")
  `ADT_ASSERT(a_result_from_decide, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == S_DECIDE), "result appeared outside the decision cycle")
  `ADT_ASSERT(a_dbl_clears_count, clk_i, rst_ni, (advance && dbl) |=> (cnt_q == '0) && out_dbl_q, "double tap did not clear the tap count")
  `ADT_ASSERT_ALWAYS(a_tap_implies_settle, clk_i, (out_vld_q && out_tap_q) |-> out_set_q, "new tap reported without settling")

endmodule

/* verif/tb_accel_double_tap_detector.sv */
`timescale 1ns / 100ps

// Self-checking bench for the double tap detector.
// Samples go in on s_axis. The expected result of each accepted sample is
// worked out by a local predictor and queued, and the checker compares each
// m_axis transaction with the oldest queued result, one field at a time.
// Registers are rewritten over APB between phases, only once every pending
// result has come back.
module tb_accel_double_tap_detector import adt_pkg::*; ();

  localparam int IDLE_PCT        = 27;    // percent of cycles a side idles
  localparam int DRAIN_CYCLES    = 24;    // extra wait once no result is pending
  localparam int HOLD_OFF_CYCLES = 200;   // long m_axis stall
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction at all

  typedef struct packed {
    logic double_tap;
    logic tap_start;
    logic settling;
  } tap_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] magnitude
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] double_tap, [1] tap_start, [2] settling
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  accel_double_tap_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Detector state as the bench sees it, plus its own copy of the registers.
  logic [SAMPLE_BITS-1:0] window_q [WINDOW_DEPTH];
  logic                   tap_mark_q [WINDOW_DEPTH];
  logic [PTR_W-1:0]       wr_pos_q;
  logic [5:0]             tap_count_q;
  logic                   settle_q;
  logic [15:0]            min_delta_q;
  logic [15:0]            settle_delta_q;
  logic [5:0]             taps_needed_q;
  logic [15:0]            fill_value_q;

  tap_result_t pending_results[$];

  // Bench control and bookkeeping
  bit no_idle;
  int hold_left;
  int errors;
  int n_samples;
  int n_results;
  int n_taps;
  int n_doubles;
  int n_settings;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void refill_window();
    for (int i = 0; i < WINDOW_DEPTH; i++) window_q[i] = fill_value_q;
  endfunction

  // Advance the detector state by one sample and return its result.
  function automatic tap_result_t predict_sample(input logic [15:0] mag);
    tap_result_t      r;
    logic [19:0]      diff_sum;
    logic [PTR_W-1:0] a_idx;
    logic [PTR_W-1:0] b_idx;
    logic [15:0]      a;
    logic [15:0]      b;
    r        = '0;
    diff_sum = '0;
    window_q[wr_pos_q] = mag;
    // Walk the pairs that end at the fresh entry; pointer math wraps at 32.
    for (int k = 0; k < KERNEL_PAIRS; k++) begin
      a_idx = wr_pos_q - PTR_W'(k);
      b_idx = a_idx - 1'b1;
      a = window_q[a_idx];
      b = window_q[b_idx];
      diff_sum += (a >= b) ? 20'(a - b) : 20'(b - a);
    end
    if (!settle_q) begin
      if (diff_sum > 20'(KERNEL_PAIRS) * 20'(min_delta_q)) begin
        if (tap_count_q != 6'd63) tap_count_q++;
        tap_mark_q[wr_pos_q] = 1'b1;
        settle_q    = 1'b1;
        r.tap_start = 1'b1;
      end else begin
        tap_mark_q[wr_pos_q] = 1'b0;
      end
    end else begin
      // No mark while settling; re-arm once the motion has died down.
      tap_mark_q[wr_pos_q] = 1'b0;
      if (diff_sum < 20'(KERNEL_PAIRS) * 20'(settle_delta_q)) begin
        refill_window();
        settle_q = 1'b0;
      end
    end
    wr_pos_q = wr_pos_q + 1'b1;
    // Age out the mark now under the write pointer, never below zero.
    if (tap_count_q != 6'd0 && tap_mark_q[wr_pos_q]) tap_count_q--;
    if (tap_count_q >= taps_needed_q) begin
      tap_count_q  = '0;
      refill_window();
      r.double_tap = 1'b1;
    end
    r.settling = settle_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one sample, idling first at random; predict it once accepted.
  task automatic send_sample(input logic [15:0] mag);
    tap_result_t r;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = mag;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_sample(mag);
    pending_results.push_back(r);
    n_samples++;
    if (r.tap_start) n_taps++;
    if (r.double_tap) n_doubles++;
  endtask

  // Drop valid and hold until every pending result is back and the
  // pipeline has run dry.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Two-phase APB write; update the local register copy at the write edge.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_MIN_DELTA:    min_delta_q    = value;
      REG_SETTLE_DELTA: settle_delta_q = value;
      REG_TAPS_NEEDED:  taps_needed_q  = value[5:0];
      REG_FILL_VALUE:   fill_value_q   = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] md, input logic [15:0] sd,
                            input logic [5:0] tt, input logic [15:0] fv);
    wait_idle();
    write_reg(REG_MIN_DELTA, md);
    write_reg(REG_SETTLE_DELTA, sd);
    write_reg(REG_TAPS_NEEDED, 16'(tt));
    write_reg(REG_FILL_VALUE, fv);
    n_settings++;
  endtask

  function automatic logic [15:0] clamp_sample(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------

  // Drive m_axis tready: a counted hold-off wins, else always ready with no_idle, else idle at random.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (no_idle) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(input string name, input logic exp_v,
                                      input logic act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch on result %0d: expected %b, got %b",
               $time, name, n_results, exp_v, act_v);
    end
  endfunction

  // Compare each m_axis transaction with the oldest pending result.
  always @(posedge clk_i) begin : check_results
    tap_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, none pending: expected nothing, got tdata=%h",
                 $time, m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("double_tap", exp_r.double_tap, m_axis_tdata[0]);
        check_field("tap_start", exp_r.tap_start, m_axis_tdata[1]);
        check_field("settling", exp_r.settling, m_axis_tdata[2]);
        n_results++;
      end
    end
  end

  // Abort when no transaction of any kind has happened for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, %0d cycles without a transaction, %0d results pending",
                 $time, quiet_cycles, pending_results.size());
        $display("accel_double_tap_detector regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset defaults: a flat start, then full-scale swings; the first taps, the rest come while settling.
  task automatic test_default_taps();
    send_sample(16'd8234);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
  endtask

  // Zero tap threshold and the widest settle band: every other sample
  // taps, the next re-arms; counting the prior tap, every second is a double.
  task automatic test_fast_rearm();
    set_config(16'h0000, 16'hFFFF, 6'd2, 16'h0000);
    repeat (3) begin
      send_sample(16'h0000);
      send_sample(16'hFFFF);
    end
  endtask

  // Register extremes: zero target, unreachable target, tap threshold out
  // of reach of any sum, settling that never ends, full-scale fill.
  task automatic test_config_extremes();
    set_config(16'd500, 16'd800, 6'd0, 16'hFFFF);
    send_sample(16'h1234);
    send_sample(16'hEDCB);
    set_config(16'h0000, 16'h0000, 6'd63, 16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    set_config(16'hFFFF, 16'hFFFF, 6'd1, 16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
  endtask

  // Hold off m_axis for a long stretch while samples keep coming, so the
  // output register fills and s_axis stalls.
  task automatic test_output_backpressure();
    set_config(16'd300, 16'd400, 6'd2, 16'd8234);
    no_idle   = 1'b1;
    hold_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 16; i++)
      send_sample((i % 4 == 1) ? 16'hF000 : 16'd8234);
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Tap-shaped traffic: flat lead-in, one or two spikes sized around the
  // tap threshold, a quiet tail to settle; plus noise and bare spikes.
  task automatic run_tap_bursts(input int n_items);
    int          first;
    int          roll;
    int          q;
    int          spike;
    logic [15:0] base;
    first = n_samples;
    while (n_samples - first < n_items) begin
      roll = $urandom_range(99);
      base = 16'($urandom);
      q    = $urandom_range(0, 40);
      if (roll < 70) begin
        repeat ($urandom_range(3, 10))
          send_sample(clamp_sample(int'(base) + $urandom_range(0, 2 * q) - q));
        repeat ($urandom_range(1, 2)) begin
          spike = $urandom_range(0, 4 * int'(min_delta_q) + 2000);
          repeat ($urandom_range(1, 3))
            send_sample(clamp_sample($urandom_range(1) ? int'(base) + spike
                                                       : int'(base) - spike));
          repeat ($urandom_range(2, 12))
            send_sample(clamp_sample(int'(base) + $urandom_range(0, 2 * q) - q));
        end
        repeat ($urandom_range(8, 20))
          send_sample(clamp_sample(int'(base) + $urandom_range(0, 2 * q) - q));
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 8)) send_sample(16'($urandom));
      end else begin
        repeat ($urandom_range(2, 6))
          send_sample($urandom_range(1) ? 16'hFFFF - base[15:1] : base[15:1]);
      end
    end
  endtask

  task automatic pick_random_config();
    int          roll;
    logic [15:0] md;
    logic [15:0] sd;
    logic [5:0]  tt;
    roll = $urandom_range(99);
    md   = (roll < 8) ? 16'h0000 : (roll < 12) ? 16'hFFFF : 16'($urandom_range(100, 3000));
    roll = $urandom_range(99);
    sd   = (roll < 5) ? 16'h0000 : (roll < 10) ? 16'hFFFF : 16'($urandom_range(50, 3000));
    roll = $urandom_range(99);
    tt   = (roll < 5) ? 6'd0 : (roll < 10) ? 6'd63 : (roll < 20) ? 6'd32 :
           (roll < 35) ? 6'($urandom_range(4, 31)) : 6'($urandom_range(1, 3));
    set_config(md, sd, tt, 16'($urandom));
  endtask

  task automatic test_random_bursts();
    for (int p = 0; p < 12; p++) begin
      pick_random_config();
      run_tap_bursts(85);
    end
  endtask

  // One long phase with neither side idling.
  task automatic test_back_to_back();
    pick_random_config();
    no_idle = 1'b1;
    run_tap_bursts(130);
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    hold_left     = 0;
    errors        = 0;
    n_samples     = 0;
    n_results     = 0;
    n_taps        = 0;
    n_doubles     = 0;
    n_settings    = 1;
    quiet_cycles  = 0;

    // Reset values of the registers and the detector state.
    min_delta_q    = 16'd500;
    settle_delta_q = 16'd800;
    taps_needed_q  = 6'd2;
    fill_value_q   = 16'd8234;
    refill_window();
    for (int i = 0; i < WINDOW_DEPTH; i++) tap_mark_q[i] = 1'b0;
    wr_pos_q    = '0;
    tap_count_q = '0;
    settle_q    = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_taps();
    test_fast_rearm();
    test_config_extremes();
    test_output_backpressure();
    test_random_bursts();
    test_back_to_back();
    wait_idle();

    $display("covered %0d samples over %0d register settings, %0d taps, %0d double taps",
             n_samples, n_settings, n_taps, n_doubles);
    $display("checked %0d results, %0d errors", n_results, errors);
    if (errors == 0)
      $display("accel_double_tap_detector regression: pass");
    else
      $display("accel_double_tap_detector regression: fail");
    $finish;
  end

endmodule
